[design/tvkp_pkg.sv]
// Shared constants, codes and types for the TV-typewriter video and keyboard port.
`timescale 1ns / 1ps
`default_nettype none
package tvkp_pkg;

   // Screen geometry
   localparam int SCREEN_CHARS = 256;
   localparam int GROUP_SIZE   = 4;
   localparam int ROW_CHARS    = 32;
   localparam int GROUP_COUNT  = (SCREEN_CHARS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int ADDR_W       = $clog2(SCREEN_CHARS);
   localparam int GRP_W        = $clog2(GROUP_COUNT);

   // Command queue between front and back
   localparam int FIFO_DEPTH = 4;

   localparam logic [7:0] HIGH_BIT  = 8'h80;
   localparam logic [7:0] HOME_CODE = 8'hFF;

   // Request mode codes
   localparam logic [2:0] MODE_PORT_WRITE = 3'd0;
   localparam logic [2:0] MODE_VIDEO_READ = 3'd1;
   localparam logic [2:0] MODE_KEY_READ   = 3'd2;
   localparam logic [2:0] MODE_KEY_PRESS  = 3'd3;
   localparam logic [2:0] MODE_END_FRAME  = 3'd4;

   // Result kinds
   localparam logic KIND_READ    = 1'b0;
   localparam logic KIND_REPAINT = 1'b1;

   typedef enum logic [2:0] {
      OP_HOME,
      OP_STORE,
      OP_VREAD,
      OP_KREAD,
      OP_KEY,
      OP_FRAME
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] arg;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_VREAD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

[design/tvkp_front.sv]
// Front end: takes request items, tracks the port edge and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none
module tvkp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_mode,
   input  wire logic [7:0]       req_port_byte,
   input  wire logic [7:0]       req_read_offset,
   input  wire logic [7:0]       req_key_code,
   input  wire logic             req_is_running,
   input  wire logic             fifo_full,
   output logic                  push,
   output tvkp_pkg::cmd_type     push_cmd
);

   logic [7:0] prev_port_ff;
   logic [7:0] prev_port_in;
   logic       accept;
   logic       rise;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   // port acts only when bit 7 goes from low to high
   assign rise      = req_port_byte[7] && !prev_port_ff[7];

   always_comb begin
      push         = 1'b0;
      push_cmd.op  = tvkp_pkg::OP_HOME;
      push_cmd.arg = req_port_byte;
      if (accept) begin
         unique case (req_mode)
            tvkp_pkg::MODE_PORT_WRITE: begin
               push        = rise;
               push_cmd.op = (req_port_byte == tvkp_pkg::HOME_CODE) ?
                             tvkp_pkg::OP_HOME : tvkp_pkg::OP_STORE;
            end
            tvkp_pkg::MODE_VIDEO_READ: begin
               push         = 1'b1;
               push_cmd.op  = tvkp_pkg::OP_VREAD;
               push_cmd.arg = req_read_offset;
            end
            tvkp_pkg::MODE_KEY_READ: begin
               push        = 1'b1;
               push_cmd.op = tvkp_pkg::OP_KREAD;
            end
            tvkp_pkg::MODE_KEY_PRESS: begin
               push         = (req_key_code != 8'h00) && req_is_running &&
                              (req_key_code < tvkp_pkg::HIGH_BIT);
               push_cmd.op  = tvkp_pkg::OP_KEY;
               push_cmd.arg = req_key_code;
            end
            tvkp_pkg::MODE_END_FRAME: begin
               push        = 1'b1;
               push_cmd.op = tvkp_pkg::OP_FRAME;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      prev_port_in = prev_port_ff;
      if (accept && (req_mode == tvkp_pkg::MODE_PORT_WRITE)) begin
         prev_port_in = req_port_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_port_ff <= 8'h00;
      end else begin
         prev_port_ff <= prev_port_in;
      end
   end

endmodule
`default_nettype wire

[design/tvkp_fifo.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tvkp_fifo #(
   parameter int DEPTH = tvkp_pkg::FIFO_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tvkp_pkg::cmd_type  push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    avail,
   output tvkp_pkg::cmd_type       head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tvkp_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign avail    = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[design/tvkp_back.sv]
// Back end: video memory, cursor, key latch, dirty marks, repaint scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module tvkp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_avail,
   input  wire tvkp_pkg::cmd_type  cmd_head,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_read_data,
   output logic [5:0]              rsp_group_index,
   output logic [2:0]              rsp_group_row,
   output logic [2:0]              rsp_group_col,
   output logic                    rsp_last
);

   localparam int AW = tvkp_pkg::ADDR_W;
   localparam int GW = tvkp_pkg::GRP_W;
   localparam int SC = tvkp_pkg::SCREEN_CHARS;
   localparam int GC = tvkp_pkg::GROUP_COUNT;

   tvkp_pkg::state_type state_ff, state_in;

   logic [7:0]    vram [SC];
   logic [SC-1:0] vram_vld_ff;
   logic [7:0]    rd_data_ff;
   logic          rd_vld_ff;

   logic [AW-1:0] cursor_ff;
   logic [6:0]    held_key_ff;
   logic          pending_ff;
   logic [GC-1:0] dirty_ff;
   logic [7:0]    arg_ff;
   logic [GW-1:0] scan_idx_ff;
   logic          hold_vld_ff;
   logic [GW-1:0] hold_idx_ff;

   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   logic [7:0]    rsp_data_ff;
   logic [5:0]    rsp_grp_ff;
   logic [2:0]    rsp_row_ff;
   logic [2:0]    rsp_col_ff;
   logic          rsp_last_ff;

   // control
   logic          out_free;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic          scan_go;
   logic          out_load;
   logic          out_kind;
   logic [7:0]    out_data;
   logic          out_last;

   logic [7:0]    old_byte;
   logic [GW-1:0] cur_grp;
   logic          scan_hit;
   logic          scan_end;
   logic [AW:0]   first_char;
   logic [2:0]    hold_row;
   logic [2:0]    hold_col;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign old_byte   = rd_vld_ff ? rd_data_ff : 8'h00;
   assign cur_grp    = GW'(cursor_ff / tvkp_pkg::GROUP_SIZE);
   assign scan_hit   = dirty_ff[scan_idx_ff];
   assign scan_end   = (scan_idx_ff == GW'(GC - 1));
   assign first_char = (AW + 1)'(hold_idx_ff) * (AW + 1)'(tvkp_pkg::GROUP_SIZE);
   assign hold_row   = 3'(first_char / tvkp_pkg::ROW_CHARS);
   assign hold_col   = 3'((first_char % tvkp_pkg::ROW_CHARS) / tvkp_pkg::GROUP_SIZE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tvkp_pkg::ST_IDLE: begin
            if (cmd_avail) begin
               if (cmd_head.op == tvkp_pkg::OP_STORE) begin
                  state_in = tvkp_pkg::ST_STORE;
               end else if (cmd_head.op == tvkp_pkg::OP_VREAD) begin
                  state_in = tvkp_pkg::ST_VREAD;
               end else if ((cmd_head.op == tvkp_pkg::OP_FRAME) && pending_ff) begin
                  state_in = tvkp_pkg::ST_SCAN;
               end
            end
         end
         tvkp_pkg::ST_STORE: begin
            state_in = tvkp_pkg::ST_IDLE;
         end
         tvkp_pkg::ST_VREAD: begin
            if (out_free) begin
               state_in = tvkp_pkg::ST_IDLE;
            end
         end
         tvkp_pkg::ST_SCAN: begin
            if (!(scan_hit && hold_vld_ff && !out_free) && scan_end) begin
               state_in = tvkp_pkg::ST_FLUSH;
            end
         end
         tvkp_pkg::ST_FLUSH: begin
            if (!hold_vld_ff || out_free) begin
               state_in = tvkp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tvkp_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = cursor_ff;
      wr_en    = 1'b0;
      scan_go  = 1'b0;
      out_load = 1'b0;
      out_kind = tvkp_pkg::KIND_READ;
      out_data = 8'h00;
      out_last = 1'b1;
      unique case (state_ff)
         tvkp_pkg::ST_IDLE: begin
            if (cmd_avail) begin
               if (cmd_head.op == tvkp_pkg::OP_KREAD) begin
                  cmd_pop  = out_free;
                  out_load = out_free;
                  out_data = (held_key_ff != 7'd0) ? {1'b1, held_key_ff} : 8'h00;
               end else begin
                  cmd_pop = 1'b1;
               end
               if (cmd_head.op == tvkp_pkg::OP_STORE) begin
                  rd_en = 1'b1;
               end else if (cmd_head.op == tvkp_pkg::OP_VREAD) begin
                  rd_en   = 1'b1;
                  // screen size is a power of two: offset wraps by truncation
                  rd_addr = cmd_head.arg[AW-1:0];
               end
            end
         end
         tvkp_pkg::ST_STORE: begin
            wr_en = 1'b1;
         end
         tvkp_pkg::ST_VREAD: begin
            out_load = out_free;
            out_data = old_byte;
         end
         tvkp_pkg::ST_SCAN: begin
            // a held group goes out once the next dirty one proves it is not last
            scan_go  = !(scan_hit && hold_vld_ff && !out_free);
            out_load = scan_hit && hold_vld_ff && out_free;
            out_kind = tvkp_pkg::KIND_REPAINT;
            out_last = 1'b0;
         end
         tvkp_pkg::ST_FLUSH: begin
            out_load = hold_vld_ff && out_free;
            out_kind = tvkp_pkg::KIND_REPAINT;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvkp_pkg::ST_IDLE;
         cursor_ff    <= '0;
         held_key_ff  <= 7'd0;
         pending_ff   <= 1'b0;
         dirty_ff     <= '0;
         vram_vld_ff  <= '0;
         scan_idx_ff  <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // a load only happens when the register is free
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         if (cmd_pop) begin
            unique case (cmd_head.op)
               tvkp_pkg::OP_HOME:  cursor_ff   <= '0;
               tvkp_pkg::OP_KREAD: held_key_ff <= 7'd0;
               tvkp_pkg::OP_KEY:   held_key_ff <= cmd_head.arg[6:0];
               tvkp_pkg::OP_FRAME: begin
                  pending_ff  <= 1'b0;
                  scan_idx_ff <= '0;
                  hold_vld_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (wr_en) begin
            if (old_byte != arg_ff) begin
               dirty_ff[cur_grp] <= 1'b1;
               pending_ff        <= 1'b1;
            end
            vram_vld_ff[cursor_ff] <= 1'b1;
            cursor_ff <= (cursor_ff == AW'(SC - 1)) ? '0 : cursor_ff + 1'b1;
         end
         if (scan_go) begin
            if (scan_hit) begin
               dirty_ff[scan_idx_ff] <= 1'b0;
               hold_vld_ff           <= 1'b1;
               hold_idx_ff           <= scan_idx_ff;
            end
            if (!scan_end) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
      end
   end

   // video memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vram[cursor_ff] <= arg_ff;
      end
      if (rd_en) begin
         rd_data_ff <= vram[rd_addr];
         rd_vld_ff  <= vram_vld_ff[rd_addr];
      end
      if (cmd_pop) begin
         arg_ff <= cmd_head.arg;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_data_ff <= out_data;
         rsp_last_ff <= out_last;
         if (out_kind == tvkp_pkg::KIND_REPAINT) begin
            rsp_grp_ff <= 6'(hold_idx_ff);
            rsp_row_ff <= hold_row;
            rsp_col_ff <= hold_col;
         end else begin
            rsp_grp_ff <= 6'd0;
            rsp_row_ff <= 3'd0;
            rsp_col_ff <= 3'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_group_index = rsp_grp_ff;
   assign rsp_group_row   = rsp_row_ff;
   assign rsp_group_col   = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

[design/tv_typewriter_video_keyboard_port.sv]
// Top level of the TV-typewriter video port with keyboard latch.
//
// Request channel (req_*): one item per access: port write, video read, keyboard read,
// key press or end of frame. Accepted when req_valid is high and req_stall low.
// Result channel (rsp_*): read results (kind 0) and dirty groups to repaint (kind 1);
// rsp_last marks the final result of an item. Taken when rsp_valid is high, rsp_stall low.
// The front end classifies each item at once and queues a command; writes without a
// rising bit 7, rejected key presses and unused modes are dropped there.
// The back end runs one command at a time: home and key press finish in the idle state;
// a store passes idle (read old byte) and store (write). A keyboard read result is
// loaded from the idle state, a video read result from the vread state after the memory
// read. End of frame walks the 64 dirty marks one per cycle unless a result stall holds
// it; the flush state sends the last group. The command queue keeps accepting items.
// The registered video memory read sets the store and read cost.
// Reset clears the cursor, key latch, port edge history, dirty marks and per-character
// valid bits, so the whole screen reads as zero at once with no clearing pass.
// A stalled receiver holds the result register; the back end then waits and the queue
// fills, after which req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module tv_typewriter_video_keyboard_port #(
   parameter int FIFO_DEPTH = tvkp_pkg::FIFO_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_mode,
   input  wire logic [7:0] req_port_byte,
   input  wire logic [7:0] req_read_offset,
   input  wire logic [7:0] req_key_code,
   input  wire logic       req_is_running,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_read_data,
   output logic [5:0]      rsp_group_index,
   output logic [2:0]      rsp_group_row,
   output logic [2:0]      rsp_group_col,
   output logic            rsp_last
);

   logic              fifo_full;
   logic              push;
   tvkp_pkg::cmd_type push_cmd;
   logic              cmd_avail;
   logic              cmd_pop;
   tvkp_pkg::cmd_type cmd_head;

   // classify and queue
   tvkp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_port_byte   (req_port_byte),
      .req_read_offset (req_read_offset),
      .req_key_code    (req_key_code),
      .req_is_running  (req_is_running),
      .fifo_full       (fifo_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   tvkp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (cmd_pop),
      .avail    (cmd_avail),
      .head_cmd (cmd_head)
   );

   // execute and report
   tvkp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_avail       (cmd_avail),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_group_index (rsp_group_index),
      .rsp_group_row   (rsp_group_row),
      .rsp_group_col   (rsp_group_col),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

[tb/sv/tv_typewriter_video_keyboard_port_test.sv]
// Self-checking testbench for the TV-typewriter video port with keyboard latch.
`timescale 1ns / 1ps
module tv_typewriter_video_keyboard_port_test;

   localparam int HALF_PERIOD_NS = 2;
   localparam int RESET_CYCLES   = 7;
   // The frame scan walks 64 marks one per cycle; allow that plus result stalls.
   localparam int DRAIN_CYCLES   = 200;
   // Well above the worst case, every item a full repaint under the longest stalls.
   localparam int CYCLE_LIMIT    = 1_000_000;
   // Items in the random mix; a store counts as its two port writes.
   localparam int RANDOM_ITEMS   = 120;

   // Modes the block must ignore.
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] port_byte;
      logic [7:0] read_offset;
      logic [7:0] key_code;
      logic       is_running;
   } port_access_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] read_data;
      logic [5:0] group_index;
      logic [2:0] group_row;
      logic [2:0] group_col;
      logic       last;
   } port_reply_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode        = tvkp_pkg::MODE_PORT_WRITE;
   logic [7:0] req_port_byte   = 8'h00;
   logic [7:0] req_read_offset = 8'h00;
   logic [7:0] req_key_code    = 8'h00;
   logic       req_is_running  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_read_data;
   logic [5:0] rsp_group_index;
   logic [2:0] rsp_group_row;
   logic [2:0] rsp_group_col;
   logic       rsp_last;

   tv_typewriter_video_keyboard_port i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_port_byte   (req_port_byte),
      .req_read_offset (req_read_offset),
      .req_key_code    (req_key_code),
      .req_is_running  (req_is_running),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_group_index (rsp_group_index),
      .rsp_group_row   (rsp_group_row),
      .rsp_group_col   (rsp_group_col),
      .rsp_last        (rsp_last)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Items still to be offered, and replies the screen model says must come back.
   port_access_type access_queue[$];
   port_reply_type  awaited_replies[$];

   // Screen model: our own copy of everything the port remembers.
   logic [7:0]                  screen_copy [tvkp_pkg::SCREEN_CHARS];
   logic                        dirty_copy  [tvkp_pkg::GROUP_COUNT];
   logic                        repaint_due   = 1'b0;
   logic [tvkp_pkg::ADDR_W-1:0] cursor_copy   = '0;
   logic [7:0]                  last_port_val = 8'h00;
   logic [6:0]                  latched_key   = 7'h00;

   // Run statistics
   int unsigned mismatches      = 0;
   int unsigned accepted_items  = 0;
   int unsigned chars_stored    = 0;
   int unsigned frames_ended    = 0;
   int unsigned replies_checked = 0;
   int unsigned repaints_seen   = 0;
   int unsigned cycle_count     = 0;

   // Idle shaping: calm spells give back-to-back traffic on both sides.
   logic       calm       = 1'b0;
   logic [7:0] calm_timer = 8'h00;
   int unsigned idle_left  = 0;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      calm_timer <= calm_timer + 8'd1;
      if (calm_timer == 8'hFF) begin
         calm <= ($urandom_range(2, 0) == 0);
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(20, 6);
   endfunction

   // Apply one accepted item to the screen model and queue the replies it owes.
   task automatic update_screen_model(input port_access_type acc);
      port_reply_type reply;
      port_reply_type held;
      logic           have_held;
      int             g;
      reply = '0;
      case (acc.mode)
         tvkp_pkg::MODE_PORT_WRITE: begin
            // Only a rising bit 7 does anything beyond updating the edge history
            if (acc.port_byte[7] && !last_port_val[7]) begin
               if (acc.port_byte == tvkp_pkg::HOME_CODE) begin
                  cursor_copy = '0;
               end else begin
                  if (screen_copy[cursor_copy] != acc.port_byte) begin
                     dirty_copy[int'(cursor_copy) / tvkp_pkg::GROUP_SIZE] = 1'b1;
                     repaint_due = 1'b1;
                  end
                  screen_copy[cursor_copy] = acc.port_byte;
                  cursor_copy = cursor_copy + 1'b1;
                  chars_stored++;
               end
            end
            last_port_val = acc.port_byte;
         end
         tvkp_pkg::MODE_VIDEO_READ: begin
            reply.kind      = tvkp_pkg::KIND_READ;
            reply.read_data = screen_copy[int'(acc.read_offset) % tvkp_pkg::SCREEN_CHARS];
            reply.last      = 1'b1;
            awaited_replies.push_back(reply);
         end
         tvkp_pkg::MODE_KEY_READ: begin
            reply.kind = tvkp_pkg::KIND_READ;
            if (latched_key != 7'h00) begin
               reply.read_data = {1'b1, latched_key};
               latched_key     = 7'h00;
            end
            reply.last = 1'b1;
            awaited_replies.push_back(reply);
         end
         tvkp_pkg::MODE_KEY_PRESS: begin
            if (acc.key_code != 8'h00 && acc.is_running &&
                acc.key_code < tvkp_pkg::HIGH_BIT) begin
               latched_key = acc.key_code[6:0];
            end
         end
         tvkp_pkg::MODE_END_FRAME: begin
            frames_ended++;
            if (repaint_due) begin
               repaint_due = 1'b0;
               have_held   = 1'b0;
               held        = '0;
               // Each group is held back one step so the final one can carry last
               for (g = 0; g < tvkp_pkg::GROUP_COUNT; g++) begin
                  if (dirty_copy[g]) begin
                     dirty_copy[g] = 1'b0;
                     if (have_held) awaited_replies.push_back(held);
                     held             = '0;
                     held.kind        = tvkp_pkg::KIND_REPAINT;
                     held.group_index = 6'(g);
                     held.group_row   = 3'((g * tvkp_pkg::GROUP_SIZE) / tvkp_pkg::ROW_CHARS);
                     held.group_col   = 3'(((g * tvkp_pkg::GROUP_SIZE) % tvkp_pkg::ROW_CHARS)
                                           / tvkp_pkg::GROUP_SIZE);
                     have_held        = 1'b1;
                  end
               end
               if (have_held) begin
                  held.last = 1'b1;
                  awaited_replies.push_back(held);
               end
            end
         end
         default: ;   // spare modes change nothing
      endcase
   endtask

   // Item driver: offers queued items, with random gaps after each acceptance.
   always @(posedge clock) begin : access_driver
      int unsigned     gap;
      port_access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         gap = 0;
         if (req_valid) begin
            update_screen_model({req_mode, req_port_byte, req_read_offset, req_key_code,
                                 req_is_running});
            accepted_items++;
            gap = pick_idle();
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            idle_left <= gap - 1;
         end else if (!req_valid && idle_left != 0) begin
            idle_left <= idle_left - 1;
         end else if (access_queue.size() != 0) begin
            nxt = access_queue.pop_front();
            req_mode        <= nxt.mode;
            req_port_byte   <= nxt.port_byte;
            req_read_offset <= nxt.read_offset;
            req_key_code    <= nxt.key_code;
            req_is_running  <= nxt.is_running;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: rsp_%s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      end
   endtask

   // Result monitor: checks each taken result against the oldest awaited reply,
   // and throttles the result channel.
   always @(posedge clock) begin : reply_monitor
      int unsigned    hold;
      port_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               mismatches++;
               $display("%0t ns: result with none awaited, kind %0d data 0x%0h group %0d",
                        $time, rsp_kind, rsp_read_data, rsp_group_index);
            end else begin
               want = awaited_replies.pop_front();
               check_field("kind",        want.kind,        rsp_kind);
               check_field("read_data",   want.read_data,   rsp_read_data);
               check_field("group_index", want.group_index, rsp_group_index);
               check_field("group_row",   want.group_row,   rsp_group_row);
               check_field("group_col",   want.group_col,   rsp_group_col);
               check_field("last",        want.last,        rsp_last);
               replies_checked++;
               if (want.kind == tvkp_pkg::KIND_REPAINT) repaints_seen++;
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            hold = pick_idle();
            rsp_stall <= (hold != 0);
            if (hold != 0) stall_left <= hold - 1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tv_typewriter_video_keyboard_port_test failed");
         $finish;
      end
   end

   task automatic queue_access(input logic [2:0] mode, input logic [7:0] port_byte,
                               input logic [7:0] read_offset, input logic [7:0] key_code,
                               input logic is_running);
      port_access_type acc;
      acc.mode        = mode;
      acc.port_byte   = port_byte;
      acc.read_offset = read_offset;
      acc.key_code    = key_code;
      acc.is_running  = is_running;
      access_queue.push_back(acc);
   endtask

   // A well-formed store: a byte with bit 7 clear, then the character, giving the edge.
   task automatic queue_store(input logic [7:0] ch);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, {1'b0, 7'($urandom)}, 8'($urandom),
                   8'($urandom), 1'($urandom));
      queue_access(tvkp_pkg::MODE_PORT_WRITE, ch, 8'($urandom), 8'($urandom),
                   1'($urandom));
   endtask

   // Characters from a small pool repeat often, so unchanged stores occur.
   function automatic logic [7:0] pick_character();
      logic [7:0] ch;
      case ($urandom_range(4, 0))
         0:       ch = 8'h80;
         1:       ch = 8'hC1;
         default: ch = {1'b1, 7'($urandom)};
      endcase
      if (ch == tvkp_pkg::HOME_CODE) ch = 8'hFE;
      return ch;
   endfunction

   initial begin
      int unsigned counted;
      int unsigned pick;
      logic [2:0]  spare;

      foreach (screen_copy[k]) screen_copy[k] = 8'h00;
      foreach (dirty_copy[k])  dirty_copy[k]  = 1'b0;

      // Directed opening: empty latch, reads of a blank screen, empty frame end
      queue_access(tvkp_pkg::MODE_KEY_READ,   8'h00, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_VIDEO_READ, 8'hFF, 8'h00, 8'hFF, 1'b1);
      queue_access(tvkp_pkg::MODE_VIDEO_READ, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_END_FRAME,  8'h00, 8'h00, 8'h00, 1'b0);
      // Edge detection: held-high bit 7 must not store twice
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'h00, 8'hFF, 8'hFF, 1'b1);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'hC1, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'hC2, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'h7F, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'hFE, 8'h00, 8'h00, 1'b0);
      // Home, then rewrite the same character: no new dirty mark
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, tvkp_pkg::HOME_CODE, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'h55, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'hC1, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_VIDEO_READ, 8'h00, 8'h01, 8'h00, 1'b0);
      // Rejected key presses: zero, top bit set, machine halted
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, 8'h00, 1'b1);
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, tvkp_pkg::HIGH_BIT, 1'b1);
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, 8'hFF, 1'b1);
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, 8'h41, 1'b0);
      queue_access(tvkp_pkg::MODE_KEY_READ,   8'h00, 8'h00, 8'h00, 1'b0);
      // Accepted keys, the second overwriting the first, then read and clear
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, 8'h7F, 1'b1);
      queue_access(tvkp_pkg::MODE_KEY_PRESS,  8'h00, 8'h00, 8'h01, 1'b1);
      queue_access(tvkp_pkg::MODE_KEY_READ,   8'h00, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_KEY_READ,   8'h00, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_END_FRAME,  8'h00, 8'h00, 8'h00, 1'b0);
      for (spare = MODE_SPARE_LO; spare <= MODE_SPARE_HI && spare >= MODE_SPARE_LO;
           spare++) begin
         queue_access(spare, 8'hFF, 8'hFF, 8'h41, 1'b1);
      end
      queue_access(tvkp_pkg::MODE_END_FRAME,  8'h00, 8'h00, 8'h00, 1'b0);

      // Random mix, weighted towards well-formed stores
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            queue_store(pick_character());
            counted++;
         end else if (pick < 45) begin
            queue_store(tvkp_pkg::HOME_CODE);
            counted++;
         end else if (pick < 52) begin
            queue_access(tvkp_pkg::MODE_PORT_WRITE, 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom));
         end else if (pick < 62) begin
            queue_access(tvkp_pkg::MODE_VIDEO_READ, 8'($urandom),
                         ($urandom_range(3, 0) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(15, 0)),
                         8'($urandom), 1'($urandom));
         end else if (pick < 71) begin
            queue_access(tvkp_pkg::MODE_KEY_PRESS, 8'($urandom), 8'($urandom),
                         ($urandom_range(4, 0) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(127, 1)),
                         ($urandom_range(4, 0) != 0));
         end else if (pick < 80) begin
            queue_access(tvkp_pkg::MODE_KEY_READ, 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom));
         end else if (pick < 94) begin
            queue_access(tvkp_pkg::MODE_END_FRAME, 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom));
         end else begin
            queue_access(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'($urandom));
         end
         counted++;
      end
      queue_access(tvkp_pkg::MODE_END_FRAME,  8'h00, 8'h00, 8'h00, 1'b0);
      queue_access(tvkp_pkg::MODE_VIDEO_READ, 8'h00, 8'hFF, 8'h00, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything offered, every reply back, then a quiet spell for strays
      while (access_queue.size() != 0 || req_valid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d characters stored, %0d frame ends,",
               accepted_items, chars_stored, frames_ended);
      $display("and %0d results checked, %0d of them repaint groups.",
               replies_checked, repaints_seen);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("tv_typewriter_video_keyboard_port_test passed");
      end else begin
         $display("tv_typewriter_video_keyboard_port_test failed");
      end
      $finish;
   end

endmodule

[tv_typewriter_video_keyboard_port.f]
design/tvkp_pkg.sv
design/tvkp_front.sv
design/tvkp_fifo.sv
design/tvkp_back.sv
design/tv_typewriter_video_keyboard_port.sv
tb/sv/tv_typewriter_video_keyboard_port_test.sv
